FILE: rtl/wst_pkg.sv
// ----------------------------------------------------------------------------
// wst_pkg
// shared types and constants of the weekly switch-point timer
// ----------------------------------------------------------------------------
package wst_pkg;

    // item kinds carried in s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // day 0 selects the top bit of the mask
    localparam logic [7:0] DAY_BIT_TOP = 8'h80;

    // one switch point as kept in the table memory
    typedef struct packed {
        logic [7:0] action;
        logic [7:0] mask;
        logic [7:0] minute;
        logic [7:0] hour;
    } point_t;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

FILE: rtl/weekly_switchpoint_timer_unit.sv
// ----------------------------------------------------------------------------
// weekly_switchpoint_timer_unit
// weekly time switch: switch-point table in a synchronous memory, scanned
// one entry per cycle on each minute tick
// ----------------------------------------------------------------------------
// sequence: a write transfer goes straight to the result state; a tick transfer
//   scans entries_in_use entries, capped at MAX_ENTRIES, through the registered
//   read port, compares the last read, then goes to the result state
// throughput: one item at a time; the next transfer is taken once the result is
//   loaded, later while a result waits downstream
// reset: aresetn synchronous, active low; clears control state; table undefined
module weekly_switchpoint_timer_unit #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration: entries_in_use
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,

    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata, from bit 0: entry_index[5:0], entry_hour[13:6], entry_minute[21:14],
    // entry_day_mask[29:22], entry_action[37:30], now_day[40:38],
    // now_hour[45:41], now_minute[51:46], zero fill[55:52]
    input  logic [55:0] s_tdata,
    // tuser: operation (0 write entry, 1 minute tick)
    input  logic        s_tuser,

    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata, from bit 0: switch_output[7:0], active_valid[8],
    // active_index[14:9], zero fill[15]
    output logic [15:0] m_tdata,
    // tuser: updated
    output logic        m_tuser
);

    import wst_pkg::*;

    // table address width, at least one bit
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // input field split
    logic [5:0] in_index;
    point_t     in_point;
    logic [2:0] in_day;
    logic [4:0] in_hour;
    logic [5:0] in_minute;

    assign in_index        = s_tdata[5:0];
    assign in_point.hour   = s_tdata[13:6];
    assign in_point.minute = s_tdata[21:14];
    assign in_point.mask   = s_tdata[29:22];
    assign in_point.action = s_tdata[37:30];
    assign in_day          = s_tdata[40:38];
    assign in_hour         = s_tdata[45:41];
    assign in_minute       = s_tdata[51:46];

    // control state
    state_t     state_reg, state_next;
    logic [6:0] entries_reg, entries_next;
    logic       applied_valid_reg, applied_valid_next;
    logic [5:0] applied_index_reg, applied_index_next;
    logic [7:0] level_reg, level_next;
    logic       m_tvalid_reg, m_tvalid_next;

    // scan state
    logic [6:0]    cnt_reg, cnt_next;        // next entry to read, up to the limit
    logic [6:0]    limit_reg, limit_next;    // entries scanned on this tick
    logic          pend_reg, pend_next;      // read data of the last cycle is live
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic          tick_reg, tick_next;
    logic [2:0]    day_reg, day_next;
    logic [4:0]    hour_reg, hour_next;
    logic [5:0]    minute_reg, minute_next;
    logic          found_reg, found_next;
    logic [7:0]    best_h_reg, best_h_next;
    logic [7:0]    best_m_reg, best_m_next;
    logic [5:0]    best_idx_reg, best_idx_next;
    logic [7:0]    best_act_reg, best_act_next;

    // result payload
    logic [15:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    // table memory
    point_t        mem [MAX_ENTRIES];
    point_t        rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    // scan compare
    logic [7:0] day_bit;
    logic       day_ok;
    logic       passed;
    logic       later;
    logic       cand;
    logic       out_free;
    logic       win;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // candidate test on the entry read in the previous cycle
    assign day_bit = DAY_BIT_TOP >> day_reg;
    assign day_ok  = |(rd_data_reg.mask & day_bit);
    assign passed  = (rd_data_reg.hour < {3'b000, hour_reg}) ||
                     ((rd_data_reg.hour == {3'b000, hour_reg}) &&
                      (rd_data_reg.minute <= {2'b00, minute_reg}));
    assign later   = (rd_data_reg.hour > best_h_reg) ||
                     ((rd_data_reg.hour == best_h_reg) &&
                      (rd_data_reg.minute > best_m_reg));
    assign cand    = pend_reg && day_ok && passed && later;

    // new switch point chosen by this tick
    assign win = tick_reg && found_reg &&
                 (!applied_valid_reg || (applied_index_reg != best_idx_reg));

    // table write on a write item transfer, slots beyond the table dropped
    assign mem_we = s_tvalid && s_tready && (s_tuser == OP_WRITE) &&
                    ({1'b0, in_index} < 7'(MAX_ENTRIES));
    assign mem_wa = in_index[AW-1:0];
    assign mem_re = (state_reg == ST_SCAN) && (cnt_reg < limit_reg);
    assign mem_ra = cnt_reg[AW-1:0];

    always_comb begin
        state_next         = state_reg;
        entries_next       = entries_reg;
        applied_valid_next = applied_valid_reg;
        applied_index_next = applied_index_reg;
        level_next         = level_reg;
        m_tvalid_next      = m_tvalid_reg;
        cnt_next           = cnt_reg;
        limit_next         = limit_reg;
        pend_next          = 1'b0;
        pend_idx_next      = pend_idx_reg;
        tick_next          = tick_reg;
        day_next           = day_reg;
        hour_next          = hour_reg;
        minute_next        = minute_reg;
        found_next         = found_reg;
        best_h_next        = best_h_reg;
        best_m_next        = best_m_reg;
        best_idx_next      = best_idx_reg;
        best_act_next      = best_act_reg;
        m_tdata_next       = m_tdata_reg;
        m_tuser_next       = m_tuser_reg;

        if (cfg_valid && cfg_ready) begin
            entries_next = cfg_data;
        end

        // output register drains
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    tick_next   = (s_tuser == OP_TICK);
                    day_next    = in_day;
                    hour_next   = in_hour;
                    minute_next = in_minute;
                    // winner starts at 00:00, none chosen
                    found_next  = 1'b0;
                    best_h_next = '0;
                    best_m_next = '0;
                    cnt_next    = '0;
                    // cap the scan at the table size
                    limit_next  = (entries_reg > 7'(MAX_ENTRIES)) ?
                                  7'(MAX_ENTRIES) : entries_reg;
                    state_next  = (s_tuser == OP_TICK) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (mem_re) begin
                    cnt_next      = cnt_reg + 7'd1;
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[AW-1:0];
                end
                if (cand) begin
                    found_next    = 1'b1;
                    best_h_next   = rd_data_reg.hour;
                    best_m_next   = rd_data_reg.minute;
                    best_idx_next = 6'(pend_idx_reg);
                    best_act_next = rd_data_reg.action;
                end
                // last read compared, scan over
                if (!mem_re && !pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (win) begin
                        applied_valid_next = 1'b1;
                        applied_index_next = best_idx_reg;
                        level_next         = best_act_reg;
                    end
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = win;
                    m_tdata_next  = win ?
                        {1'b0, best_idx_reg, 1'b1, best_act_reg} :
                        {1'b0, applied_index_reg, applied_valid_reg, level_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            entries_reg       <= '0;
            applied_valid_reg <= 1'b0;
            applied_index_reg <= '0;
            level_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
            pend_reg          <= 1'b0;
            found_reg         <= 1'b0;
        end else begin
            state_reg         <= state_next;
            entries_reg       <= entries_next;
            applied_valid_reg <= applied_valid_next;
            applied_index_reg <= applied_index_next;
            level_reg         <= level_next;
            m_tvalid_reg      <= m_tvalid_next;
            pend_reg          <= pend_next;
            found_reg         <= found_next;
        end
    end

    // payload and scan registers
    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        limit_reg    <= limit_next;
        pend_idx_reg <= pend_idx_next;
        tick_reg     <= tick_next;
        day_reg      <= day_next;
        hour_reg     <= hour_next;
        minute_reg   <= minute_next;
        best_h_reg   <= best_h_next;
        best_m_reg   <= best_m_next;
        best_idx_reg <= best_idx_next;
        best_act_reg <= best_act_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // table memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= in_point;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

`ifndef SYNTHESIS
    // scan never reads past the capped entry count
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= limit_reg))
        else $error("scan counter beyond entry limit");

    // a chosen point is always strictly after 00:00
    a_found_time: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> ((best_h_reg != 8'd0) || (best_m_reg != 8'd0)))
        else $error("winner at 00:00");

    // once applied, a switch point stays applied until reset
    a_applied_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        applied_valid_reg |=> applied_valid_reg)
        else $error("applied state lost");

    // an update result always reports an applied point
    a_update_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> m_tdata_reg[8])
        else $error("update without applied point");
`endif

endmodule

FILE: tb/sv/tb_weekly_switchpoint_timer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weekly_switchpoint_timer_unit
// self-checking bench for the weekly time switch: a short directed sequence
// followed by random phases at several scan counts, every result checked
// field by field against an in-bench model of the switch-point selection
// ----------------------------------------------------------------------------
module tb_weekly_switchpoint_timer_unit;
    import wst_pkg::*;

    localparam int TABLE_SLOTS     = 64;
    localparam int IDLE_LIMIT      = 4000;  // cycles without any transfer
    localparam int HOLD_OFF_CYCLES = 600;   // long receiver stall, fills the block
    localparam int HOLD_OFF_AFTER  = 300;   // results seen before that stall
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 80;    // longest tick scans all 64 slots
    localparam int PHASE_ITEMS     = 180;
    localparam int PHASES          = 9;

    // one input item, all fields at block widths
    typedef struct packed {
        logic       op;
        logic [5:0] idx;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] mask;
        logic [7:0] action;
        logic [2:0] day;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
    } sw_item_t;

    // one result item
    typedef struct packed {
        logic       updated;
        logic [7:0] level;
        logic       vld;
        logic [5:0] idx;
    } sw_result_t;

    localparam sw_result_t RES_IDLE = '0;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        sw_item_t   item;
        logic [6:0] count;
        bit         typed;
        sw_result_t res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn    = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data   = '0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata    = '0;
    logic        s_tuser    = 1'b0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    weekly_switchpoint_timer_unit #(
        .MAX_ENTRIES (TABLE_SLOTS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // model state of the switch
    point_t     point_mem [TABLE_SLOTS];
    bit         written [TABLE_SLOTS];
    logic [5:0] applied_idx  = '0;
    logic       applied_vld  = 1'b0;
    logic [7:0] switch_level = '0;
    logic [6:0] scan_count   = '0;

    sw_result_t expected_q [$];
    dir_row_t   dir_rows [$];
    int         errors       = 0;
    int         results_seen = 0;
    int         burst_left   = 0;
    bit         steady       = 1'b0;
    int         idle_cycles  = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // selection of the latest passed switch point, applied to the model state
    function automatic sw_result_t switch_step(input sw_item_t it);
        int unsigned n;
        logic [7:0]  day_sel;
        logic [7:0]  best_h;
        logic [7:0]  best_m;
        logic [5:0]  best_i;
        bit          found;
        point_t      p;
        sw_result_t  r;
        found     = 1'b0;
        best_h    = '0;
        best_m    = '0;
        best_i    = '0;
        r.updated = 1'b0;
        if (it.op == OP_WRITE) begin
            point_mem[it.idx] = {it.action, it.mask, it.minute, it.hour};
            written[it.idx]   = 1'b1;
        end else begin
            n       = (scan_count > TABLE_SLOTS) ? TABLE_SLOTS : scan_count;
            day_sel = DAY_BIT_TOP >> it.day;
            for (int i = 0; i < n; i++) begin
                p = point_mem[i];
                // day enabled, already passed, and strictly later than the best so far
                if ((p.mask & day_sel) != 0 &&
                    (p.hour < it.now_hour ||
                     (p.hour == it.now_hour && p.minute <= it.now_minute)) &&
                    (p.hour > best_h || (p.hour == best_h && p.minute > best_m))) begin
                    best_h = p.hour;
                    best_m = p.minute;
                    best_i = i[5:0];
                    found  = 1'b1;
                end
            end
            if (found && (!applied_vld || applied_idx != best_i)) begin
                switch_level = point_mem[best_i].action;
                applied_idx  = best_i;
                applied_vld  = 1'b1;
                r.updated    = 1'b1;
            end
        end
        r.level = switch_level;
        r.vld   = applied_vld;
        r.idx   = applied_idx;
        return r;
    endfunction

    function automatic sw_item_t rand_item(input logic op, input int cap);
        logic [63:0] raw;
        sw_item_t    it;
        raw   = {$urandom, $urandom};
        it    = raw[52:0];
        it.op = op;
        if (op == OP_WRITE) begin
            // mostly clock-like times, sometimes the whole byte range
            if ($urandom_range(0, 9) < 8) begin
                it.hour   = 8'($urandom_range(0, 23));
                it.minute = 8'($urandom_range(0, 59));
            end
            if (cap > 0 && $urandom_range(0, 3) != 0)
                it.idx = 6'($urandom_range(0, cap - 1));
        end else if ($urandom_range(0, 9) != 0) begin
            it.now_hour   = 5'($urandom_range(0, 23));
            it.now_minute = 6'($urandom_range(0, 59));
        end
        return it;
    endfunction

    function automatic void add_row(input logic op, input logic [5:0] idx,
                                    input logic [7:0] hr, input logic [7:0] mn,
                                    input logic [7:0] msk, input logic [7:0] act,
                                    input logic [2:0] day, input logic [4:0] nh,
                                    input logic [5:0] nm, input bit typed,
                                    input sw_result_t res);
        dir_row_t r;
        r.kind  = ROW_ITEM;
        r.item  = {op, idx, hr, mn, msk, act, day, nh, nm};
        r.count = '0;
        r.typed = typed;
        r.res   = res;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [6:0] v);
        dir_row_t r;
        r.kind  = ROW_CFG;
        r.item  = '0;
        r.count = v;
        r.typed = 1'b0;
        r.res   = RES_IDLE;
        dir_rows.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // offer one item and wait for its transfer; the expectation is queued at that edge
    task automatic send_item(input sw_item_t it, input bit typed, input sw_result_t fixed);
        sw_result_t r;
        s_tuser  <= it.op;
        s_tdata  <= {4'b0, it.now_minute, it.now_hour, it.day, it.action, it.mask,
                     it.minute, it.hour, it.idx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = switch_step(it);
        expected_q.push_back(typed ? fixed : r);
    endtask

    // sender bursts with random gaps between them, none in steady phases
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady) begin
                gap = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // register write only once the block has drained
    task automatic set_count(input logic [6:0] v);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        scan_count = v;
    endtask

    initial begin : stimulus
        logic [6:0] phase_counts [PHASES];
        logic [6:0] cnt;
        dir_row_t   row;
        sw_item_t   it;
        logic       op;
        int         cap;
        phase_counts = '{7'd64, 7'd1, 7'd127, 7'd16, 7'd2, 7'd65, 7'd40, 7'd8, 7'd0};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        //        op        idx  hour   min    mask   action day   nh     nm
        // tick with nothing scanned right after reset
        add_row(OP_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 5'd23, 6'd59, 1, RES_IDLE);
        // point at exactly midnight, never selectable
        add_row(OP_WRITE, 6'd0,  8'd0,  8'd0,  8'hff, 8'h11, 3'd7, 5'd31, 6'd63, 1, RES_IDLE);
        add_cfg(7'd4);
        add_row(OP_WRITE, 6'd1,  8'd8,  8'd30, 8'h80, 8'haa, 3'd0, 5'd0,  6'd0,  0, RES_IDLE);
        // same time as slot 1, all days: ties keep the lower slot
        add_row(OP_WRITE, 6'd2,  8'd8,  8'd30, 8'hff, 8'hbb, 3'd0, 5'd0,  6'd0,  0, RES_IDLE);
        // hour byte out of range, never passed
        add_row(OP_WRITE, 6'd3,  8'hff, 8'hff, 8'hff, 8'hcc, 3'd0, 5'd0,  6'd0,  0, RES_IDLE);
        add_row(OP_TICK,  6'h3f, 8'hff, 8'hff, 8'hff, 8'hff, 3'd0, 5'd0,  6'd0,  1, RES_IDLE);
        add_row(OP_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 5'd8,  6'd29, 1, RES_IDLE);
        add_row(OP_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 5'd8,  6'd30, 1,
                {1'b1, 8'haa, 1'b1, 6'd1});
        // same point again, no update
        add_row(OP_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 5'd8,  6'd30, 1,
                {1'b0, 8'haa, 1'b1, 6'd1});
        add_row(OP_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 5'd8,  6'd30, 1,
                {1'b1, 8'hbb, 1'b1, 6'd2});
        add_row(OP_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 3'd7, 5'd31, 6'd63, 1,
                {1'b0, 8'hbb, 1'b1, 6'd2});
        // slot outside the scanned range
        add_row(OP_WRITE, 6'h3f, 8'hff, 8'hff, 8'hff, 8'hff, 3'd7, 5'd31, 6'd63, 0, RES_IDLE);
        add_row(OP_WRITE, 6'd1,  8'd0,  8'd1,  8'h01, 8'h01, 3'd5, 5'd17, 6'd42, 0, RES_IDLE);
        // day 7 uses mask bit 0; entry fields are ignored on a tick
        add_row(OP_TICK,  6'h3f, 8'hff, 8'hff, 8'hff, 8'hff, 3'd7, 5'd0,  6'd1,  1,
                {1'b1, 8'h01, 1'b1, 6'd1});
        add_row(OP_WRITE, 6'd2,  8'd0,  8'd0,  8'h00, 8'h00, 3'd0, 5'd0,  6'd0,  0, RES_IDLE);
        add_row(OP_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 3'd7, 5'd23, 6'd59, 1,
                {1'b0, 8'h01, 1'b1, 6'd1});
        add_cfg(7'd0);
        add_row(OP_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 3'd3, 5'd12, 6'd0,  1,
                {1'b0, 8'h01, 1'b1, 6'd1});

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                set_count(row.count);
            end else begin
                send_item(row.item, row.typed, row.res);
                pace();
            end
        end

        // random phases at several scan counts, extremes included
        for (int ph = 0; ph < PHASES; ph++) begin
            cnt = (ph == PHASES - 1) ? 7'($urandom_range(0, 127)) : phase_counts[ph];
            set_count(cnt);
            cap    = (cnt > TABLE_SLOTS) ? TABLE_SLOTS : cnt;
            steady = (ph % 3 == 2);
            // every scanned slot gets written before the first tick
            for (int i = 0; i < cap; i++) begin
                if (!written[i]) begin
                    it     = rand_item(OP_WRITE, 0);
                    it.idx = i[5:0];
                    send_item(it, 1'b0, RES_IDLE);
                    pace();
                end
            end
            repeat (PHASE_ITEMS) begin
                op = ($urandom_range(0, 99) < 35) ? OP_WRITE : OP_TICK;
                send_item(rand_item(op, cap), 1'b0, RES_IDLE);
                pace();
            end
        end

        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver stall pattern, with one long hold-off so the block backs up
    initial begin : stall_pattern
        int len;
        int duty;
        bit held;
        held = 1'b0;
        forever begin
            if (!held && results_seen >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                len = $urandom_range(8, 80);
                case ($urandom_range(0, 3))
                    0: duty = 100;
                    1: duty = 70;
                    2: duty = 35;
                    default: duty = 90;
                endcase
                repeat (len) begin
                    m_tready <= ($urandom_range(1, 100) <= duty);
                    @(posedge aclk);
                end
            end
        end
    end

    // result transfer checked against the oldest expectation
    always @(posedge aclk) begin : result_check
        sw_result_t got;
        sw_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[14:9]};
            results_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("updated", 8'(want.updated), 8'(got.updated));
                check_field("switch_output", want.level, got.level);
                check_field("active_valid", 8'(want.vld), 8'(got.vld));
                check_field("active_index", 8'(want.idx), 8'(got.idx));
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
